// ----- rtl/tlsc_pkg.sv -----
package tlsc_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 64;
    localparam int unsigned IdxW   = 2;

    localparam logic [WordW-1:0] SEED_A = 32'h13579BDF;
    localparam logic [WordW-1:0] SEED_B = 32'h2468ACE0;
    localparam logic [WordW-1:0] SEED_C = 32'hFDB97531;

    localparam logic [WordW-1:0] MASK_A  = 32'h80000062;
    localparam logic [WordW-1:0] MASK_B  = 32'h40000020;
    localparam logic [WordW-1:0] MASK_C  = 32'h10000002;
    localparam logic [WordW-1:0] FILL0_A = 32'h7FFFFFFF;
    localparam logic [WordW-1:0] FILL0_B = 32'h3FFFFFFF;
    localparam logic [WordW-1:0] FILL0_C = 32'h0FFFFFFF;
    localparam logic [WordW-1:0] FILL1_A = 32'h80000000;
    localparam logic [WordW-1:0] FILL1_B = 32'hC0000000;
    localparam logic [WordW-1:0] FILL1_C = 32'hF0000000;

    localparam logic FUNC_XFORM  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef enum logic [IdxW-1:0] {
        CFG_KEY_A = 2'd0,
        CFG_KEY_B = 2'd1,
        CFG_KEY_C = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
    } t_lfsr_state;

endpackage

// ----- rtl/tlsc_if.sv -----
interface tlsc_in_if
    import tlsc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             func;
    logic [ByteW-1:0] data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink (input valid, input func, input data_in, output ready);
endinterface

interface tlsc_out_if
    import tlsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ByteW-1:0]  data_out;
    logic [CountW-1:0] position;

    modport source (output valid, output data_out, output position, input ready);
    modport sink (input valid, input data_out, input position, output ready);
endinterface

interface tlsc_cfg_if
    import tlsc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IdxW-1:0]  addr;
    logic [WordW-1:0] wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ----- rtl/tlsc_ks.sv -----
module tlsc_ks
    import tlsc_pkg::*;
(
    input  t_lfsr_state      i_state,
    input  logic [ByteW-1:0] i_data,
    output t_lfsr_state      o_state,
    output logic [ByteW-1:0] o_data
);

    function automatic logic [WordW-1:0] step(
        input logic [WordW-1:0] r,
        input logic [WordW-1:0] mask,
        input logic [WordW-1:0] fill0,
        input logic [WordW-1:0] fill1
    );
        if (r[0]) begin
            return (r ^ (mask >> 1)) | fill1;
        end
        return (r >> 1) & fill0;
    endfunction

    always_comb begin
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
        logic             ob;
        logic             oc;
        logic [ByteW-1:0] ks;
        a  = i_state.a;
        b  = i_state.b;
        c  = i_state.c;
        ob = b[0];
        oc = c[0];
        ks = '0;
        for (int i = 0; i < ByteW; i++) begin
            if (a[0]) begin
                a  = step(a, MASK_A, FILL0_A, FILL1_A);
                ob = b[0];
                b  = step(b, MASK_B, FILL0_B, FILL1_B);
            end else begin
                a  = step(a, MASK_A, FILL0_A, FILL1_A);
                oc = c[0];
                c  = step(c, MASK_C, FILL0_C, FILL1_C);
            end
            ks = {ks[ByteW-2:0], ob ^ oc};
        end
        o_state.a = a;
        o_state.b = b;
        o_state.c = c;
        o_data    = i_data ^ ks;
    end

endmodule

// ----- rtl/three_lfsr_stream_cipher.sv -----
// three-register stop-and-go byte stream cipher
// i_in carries one item per byte: func selects transform or restart, data_in
// is the byte to encrypt or decrypt. o_out returns one item per input item:
// data_out is data_in xor the keystream byte, position counts bytes since the
// last restart including this one. a restart returns zero in both fields and
// reloads the three registers from the keys (a zero key loads its default).
// i_cfg writes key_a, key_b, key_c at addr 0, 1, 2; other addresses are
// dropped. the config channel is always ready; write keys only while idle.
// o_out.valid rises in the cycle after acceptance. throughput is one item
// per cycle while the receiver keeps up: all eight register steps of a byte
// settle combinationally between the state registers and output register.
// a stalled receiver holds the output register; i_in.ready is high while
// that register is empty or being taken in the same cycle.
// synchronous active-low reset restores the default keys, default register
// seeds and a zero count, and empties the output register.
module three_lfsr_stream_cipher
    import tlsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlsc_in_if.sink     i_in,
    tlsc_out_if.source  o_out,
    tlsc_cfg_if.sink    i_cfg
);

    logic [WordW-1:0]  r_key_a;
    logic [WordW-1:0]  r_key_b;
    logic [WordW-1:0]  r_key_c;
    t_lfsr_state       r_state;
    t_lfsr_state       n_state;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              r_out_valid;
    logic [ByteW-1:0]  r_data_out;
    logic [ByteW-1:0]  n_data_out;
    logic [CountW-1:0] r_position;
    t_lfsr_state       ks_state;
    logic [ByteW-1:0]  ks_data;
    logic              in_fire;
    logic              cfg_fire;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_data_out;
    assign o_out.position = r_position;

    tlsc_ks u_ks (
        .i_state (r_state),
        .i_data  (i_in.data_in),
        .o_state (ks_state),
        .o_data  (ks_data)
    );

    always_comb begin
        if (i_in.func == FUNC_RESTART) begin
            n_state.a  = (r_key_a != '0) ? r_key_a : SEED_A;
            n_state.b  = (r_key_b != '0) ? r_key_b : SEED_B;
            n_state.c  = (r_key_c != '0) ? r_key_c : SEED_C;
            n_count    = '0;
            n_data_out = '0;
        end else begin
            n_state    = ks_state;
            n_count    = r_count + CountW'(1);
            n_data_out = ks_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a     <= SEED_A;
            r_key_b     <= SEED_B;
            r_key_c     <= SEED_C;
            r_state.a   <= SEED_A;
            r_state.b   <= SEED_B;
            r_state.c   <= SEED_C;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg.addr)
                    CFG_KEY_A: r_key_a <= i_cfg.wdata;
                    CFG_KEY_B: r_key_b <= i_cfg.wdata;
                    CFG_KEY_C: r_key_c <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data_out <= n_data_out;
            r_position <= n_count;
        end
    end

endmodule

// ----- rtl/tlsc_chk.sv -----
module tlsc_chk
    import tlsc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_func,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ByteW-1:0]  i_out_data,
    input logic [CountW-1:0] i_out_position
);

    logic in_fire;
    assign in_fire = i_in_valid && i_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_position))
        else $error("stalled item changed");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_func == FUNC_RESTART |=>
            i_out_valid && i_out_data == '0 && i_out_position == '0)
        else $error("restart item not zero");

    a_accept_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> i_out_valid)
        else $error("accepted item produced no result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

endmodule

bind three_lfsr_stream_cipher tlsc_chk u_tlsc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_data     (o_out.data_out),
    .i_out_position (o_out.position)
);

// ----- verif/tb_top.sv -----
module tb_top
    import tlsc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IdxW-1:0] CfgIdxSpare = 2'd3;
    localparam int unsigned RandPhases = 8;
    localparam int unsigned PhaseItems = 228;

    typedef struct packed {
        logic             func;
        logic [ByteW-1:0] data;
    } t_byte_item;

    typedef struct packed {
        logic [ByteW-1:0]  data_out;
        logic [CountW-1:0] position;
    } t_byte_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlsc_in_if  in_if ();
    tlsc_out_if out_if ();
    tlsc_cfg_if cfg_if ();

    three_lfsr_stream_cipher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // predicted cipher state
    logic [WordW-1:0]  key_a = SEED_A;
    logic [WordW-1:0]  key_b = SEED_B;
    logic [WordW-1:0]  key_c = SEED_C;
    logic [WordW-1:0]  st_a = SEED_A;
    logic [WordW-1:0]  st_b = SEED_B;
    logic [WordW-1:0]  st_c = SEED_C;
    logic [CountW-1:0] byte_cnt = '0;

    t_byte_item   stim_items[$];
    t_byte_result expected_out[$];
    t_byte_item   nxt_item;
    t_byte_result want;

    int n_fail = 0;
    int n_items = 0;
    int n_restarts = 0;
    int n_results = 0;
    int n_key_writes = 0;
    int tx_gap = 0;
    int tx_burst = 0;
    int rx_stall = 0;
    int rx_burst = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [WordW-1:0] lfsr_next(input logic [WordW-1:0] r,
                                                   input logic [WordW-1:0] mask,
                                                   input logic [WordW-1:0] fill0,
                                                   input logic [WordW-1:0] fill1);
        return r[0] ? ((r ^ (mask >> 1)) | fill1) : ((r >> 1) & fill0);
    endfunction

    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    task automatic crypt_byte(input logic func, input logic [ByteW-1:0] din);
        t_byte_result r;
        logic [ByteW-1:0] ks;
        logic ob;
        logic oc;
        ks = '0;
        if (func == FUNC_RESTART) begin
            st_a = (key_a != '0) ? key_a : SEED_A;
            st_b = (key_b != '0) ? key_b : SEED_B;
            st_c = (key_c != '0) ? key_c : SEED_C;
            byte_cnt = '0;
            r.data_out = '0;
            r.position = '0;
        end else begin
            ob = st_b[0];
            oc = st_c[0];
            for (int i = 0; i < 8; i++) begin
                if (st_a[0]) begin
                    st_a = lfsr_next(st_a, MASK_A, FILL0_A, FILL1_A);
                    ob = st_b[0];
                    st_b = lfsr_next(st_b, MASK_B, FILL0_B, FILL1_B);
                end else begin
                    st_a = lfsr_next(st_a, MASK_A, FILL0_A, FILL1_A);
                    oc = st_c[0];
                    st_c = lfsr_next(st_c, MASK_C, FILL0_C, FILL1_C);
                end
                ks = {ks[ByteW-2:0], ob ^ oc};
            end
            byte_cnt = byte_cnt + 1'b1;
            r.data_out = din ^ ks;
            r.position = byte_cnt;
        end
        expected_out.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.func <= FUNC_XFORM;
            in_if.data_in <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                crypt_byte(in_if.func, in_if.data_in);
                n_items++;
                if (in_if.func == FUNC_RESTART) n_restarts++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (stim_items.size() != 0) begin
                    nxt_item = stim_items.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.func <= nxt_item.func;
                    in_if.data_in <= nxt_item.data;
                    if (tx_burst > 0) begin
                        tx_burst--;
                        tx_gap = 0;
                    end else if ($urandom_range(0, 49) == 0) begin
                        tx_burst = $urandom_range(20, 80);
                        tx_gap = 0;
                    end else begin
                        tx_gap = ($urandom_range(0, 1) == 0) ? 0 : pick_delay();
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (expected_out.size() == 0) begin
                    $error("unexpected result: data_out %02h position %0d",
                           out_if.data_out, out_if.position);
                    n_fail++;
                end else begin
                    want = expected_out.pop_front();
                    if (out_if.data_out !== want.data_out) begin
                        $error("data_out mismatch: expected %02h actual %02h",
                               want.data_out, out_if.data_out);
                        n_fail++;
                    end
                    if (out_if.position !== want.position) begin
                        $error("position mismatch: expected %0d actual %0d",
                               want.position, out_if.position);
                        n_fail++;
                    end
                end
            end
            if (rx_burst > 0) begin
                rx_burst--;
                out_if.ready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) rx_burst = $urandom_range(20, 80);
                else if ($urandom_range(0, 2) == 0) rx_stall = pick_delay();
            end
        end
    end

    task automatic push_item(input logic func, input logic [ByteW-1:0] data);
        t_byte_item it;
        it.func = func;
        it.data = data;
        stim_items.push_back(it);
    endtask

    // holds cfg valid high; caller lowers it after the last write
    task automatic write_key(input logic [IdxW-1:0] idx, input logic [WordW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= idx;
        cfg_if.wdata <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        n_key_writes++;
        case (idx)
            CFG_KEY_A: key_a = val;
            CFG_KEY_B: key_b = val;
            CFG_KEY_C: key_c = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (stim_items.size() != 0 || in_if.valid || expected_out.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [WordW-1:0] phase_key(input int unsigned ph);
        case (ph)
            0: return '1;
            1: return 32'h0000_0001;
            2: return 32'h8000_0000;
            3: return '0;
            default: return ($urandom_range(0, 7) == 0) ? '0 : $urandom;
        endcase
    endfunction

    initial begin
        in_if.valid = 1'b0;
        in_if.func = FUNC_XFORM;
        in_if.data_in = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = '0;
        cfg_if.wdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset keys: stream from power-up state, then after a restart
        push_item(FUNC_XFORM, 8'h00);
        push_item(FUNC_XFORM, 8'hFF);
        push_item(FUNC_XFORM, 8'hAA);
        push_item(FUNC_XFORM, 8'h55);
        push_item(FUNC_RESTART, 8'hFF);
        push_item(FUNC_XFORM, 8'h01);
        push_item(FUNC_XFORM, 8'h80);
        push_item(FUNC_RESTART, 8'h00);
        push_item(FUNC_RESTART, 8'h5A);
        push_item(FUNC_XFORM, 8'h00);
        push_item(FUNC_XFORM, 8'hFF);
        wait_idle();

        // zero keys fall back to defaults, spare index is dropped
        write_key(CFG_KEY_A, '0);
        write_key(CFG_KEY_B, '1);
        write_key(CFG_KEY_C, '0);
        write_key(CfgIdxSpare, 32'hDEAD_BEEF);
        cfg_if.valid <= 1'b0;
        push_item(FUNC_XFORM, 8'h00);
        push_item(FUNC_RESTART, 8'h00);
        push_item(FUNC_XFORM, 8'hFF);
        push_item(FUNC_XFORM, 8'h00);
        push_item(FUNC_XFORM, 8'h7F);
        push_item(FUNC_RESTART, 8'h00);
        push_item(FUNC_XFORM, 8'hFE);
        push_item(FUNC_XFORM, 8'h01);
        wait_idle();

        write_key(CfgIdxSpare, '0);
        write_key(CFG_KEY_A, 32'hFFFF_FFFF);
        cfg_if.valid <= 1'b0;
        push_item(FUNC_RESTART, 8'h00);
        push_item(FUNC_XFORM, 8'hC3);
        push_item(FUNC_XFORM, 8'h3C);
        wait_idle();

        for (int unsigned ph = 0; ph < RandPhases; ph++) begin
            write_key(CFG_KEY_A, phase_key(ph));
            write_key(CFG_KEY_B, phase_key(ph));
            write_key(CFG_KEY_C, phase_key(ph));
            if ($urandom_range(0, 2) == 0) write_key(CfgIdxSpare, $urandom);
            cfg_if.valid <= 1'b0;
            // mostly restart plus a byte run; a few runs skip the restart
            if ($urandom_range(0, 5) != 0) begin
                push_item(FUNC_RESTART, ByteW'($urandom_range(0, 255)));
            end
            for (int unsigned k = 1; k < PhaseItems; k++) begin
                push_item(($urandom_range(0, 39) == 0) ? FUNC_RESTART : FUNC_XFORM,
                          ByteW'($urandom_range(0, 255)));
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("run covered %0d items (%0d restarts) and %0d results",
                 n_items, n_restarts, n_results);
        $display("%0d key writes incl. zero, all-ones and spare-index cases", n_key_writes);
        if (n_fail == 0 && expected_out.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
